// File: sv/svpwm_pkg.sv
// Shared types and constants of the space-vector PWM duty block.
// Holds the arctangent table, the sector boundary tables and the pipeline
// stage records. Depends on nothing.
package svpwm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 24;
  localparam int DIV_STEPS    = 16;
  localparam int MID_STEPS    = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
  localparam int TAIL_STAGES  = 7;
  localparam int NUM_STAGES   = (SQRT_STEPS + 1) + (MID_STEPS + 1) + TAIL_STAGES;

  localparam logic [15:0] IDX_LIMIT       = 16'd37814;
  localparam logic [15:0] IDX_LIMIT_NEXT  = 16'd37815;
  localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] QUARTER_TURN    = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN       = 32'h8000_0000;

  localparam logic [15:0] SUPPLY_RESET = 16'd3072;
  localparam logic [15:0] PERIOD_RESET = 16'd3600;

  typedef enum logic [0:0] {
    REG_SUPPLY = 1'b0,
    REG_PERIOD = 1'b1
  } svp_reg_t;

  // atan(2^-i) in 2^-32 turn units
  localparam logic [31:0] ATAN_TURNS [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458908, 32'd85004755, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // ceil(s * 2^32 / 6) and floor(s * 2^32 / 6)
  localparam logic [32:0] CEIL6 [0:7] = '{
    33'd0, 33'd715827883, 33'd1431655766, 33'd2147483648,
    33'd2863311531, 33'd3579139414, 33'd4294967296, 33'd4294967296
  };
  localparam logic [32:0] FLOOR6 [0:7] = '{
    33'd0, 33'd715827882, 33'd1431655765, 33'd2147483648,
    33'd2863311530, 33'd3579139413, 33'd4294967296, 33'd4294967296
  };

  typedef struct packed {
    logic               fast;
    logic signed [15:0] vq;
    logic [15:0]        ang;
    logic [47:0]        sq_v;
    logic [47:0]        sq_res;
    logic signed [33:0] at_x;
    logic signed [33:0] at_y;
    logic [31:0]        at_z;
  } svp_front_t;

  typedef struct packed {
    logic               neg;
    logic               clamp;
    logic               mag_zero;
    logic [2:0]         sec;
    logic [31:0]        rem;
    logic [15:0]        quo;
    logic signed [33:0] s1_x;
    logic signed [33:0] s1_y;
    logic signed [34:0] s1_z;
    logic signed [33:0] s2_x;
    logic signed [33:0] s2_y;
    logic signed [34:0] s2_z;
  } svp_mid_t;

endpackage

// File: sv/space_vector_pwm_duty.sv
// Space-vector PWM duty generator with inverse Park step, top level.
// Takes svpwm_pkg; contains the whole pipeline in one module.
//
// One word enters per cycle while no result waits stalled at the output.
// The front runs a square root one bit pair a stage beside a vectoring
// CORDIC, the middle runs a restoring divide one quotient bit a stage beside
// two rotating CORDICs, and a short tail does the dwell-time multiplies and
// saturation. The pipeline halts as a whole only while a result waits at
// the output. Configuration is written through cfg_we/cfg_index/cfg_wdata,
// and the user must write it only while the block is empty; the block itself has no check for this.
module space_vector_pwm_duty
  import svpwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_volt_q,
  input  logic signed [15:0] in_volt_d,
  input  logic [15:0]        in_elec_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_duty_a,
  output logic [15:0]        out_duty_b,
  output logic [15:0]        out_duty_c,
  output logic [2:0]         out_sector_num,
  output logic               out_clamped,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic [15:0] supply_r;
  logic [15:0] period_r;
  logic [31:0] lim_r;
  logic [NUM_STAGES-1:0] vld_r;
  logic adv;

  assign adv       = !vld_r[NUM_STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (svp_reg_t'(cfg_index))
        REG_SUPPLY: supply_r <= cfg_wdata;
        REG_PERIOD: period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp threshold: index would exceed the limit from here on
  always_ff @(posedge clk) begin
    lim_r <= 32'(supply_r) * 32'(IDX_LIMIT_NEXT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // ---------------- front: square root and vectoring CORDIC ----------------
  function automatic svp_front_t front_step(svp_front_t s, logic [47:0] bit_v,
                                            logic at_on, logic [31:0] at_a, int k);
    logic [47:0] trial;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    svp_front_t o;
    o = s;
    trial = s.sq_res + bit_v;
    if (s.sq_v >= trial) begin
      o.sq_v   = s.sq_v - trial;
      o.sq_res = (s.sq_res >> 1) + bit_v;
    end else begin
      o.sq_res = s.sq_res >> 1;
    end
    xs = $signed(s.at_x) >>> k;
    ys = $signed(s.at_y) >>> k;
    if (at_on) begin
      if ($signed(s.at_y) > 0) begin
        o.at_x = $signed(s.at_x) + ys;
        o.at_y = $signed(s.at_y) - xs;
        o.at_z = s.at_z + at_a;
      end else begin
        o.at_x = $signed(s.at_x) - ys;
        o.at_y = $signed(s.at_y) + xs;
        o.at_z = s.at_z - at_a;
      end
    end
    return o;
  endfunction

  svp_front_t front_r   [0:SQRT_STEPS];
  svp_front_t front_nxt [0:SQRT_STEPS];

  logic [31:0]        sum_sq;
  logic signed [33:0] vd_scaled;

  always_comb begin
    sum_sq    = 32'($signed(in_volt_q)) * 32'($signed(in_volt_q))
              + 32'($signed(in_volt_d)) * 32'($signed(in_volt_d));
    vd_scaled = 34'($signed(in_volt_d)) <<< 14;
    front_nxt[0].fast   = (in_volt_d == 16'sd0);
    front_nxt[0].vq     = in_volt_q;
    front_nxt[0].ang    = in_elec_angle;
    front_nxt[0].sq_v   = {sum_sq, 16'd0};
    front_nxt[0].sq_res = '0;
    if (in_volt_d[15]) begin
      front_nxt[0].at_x = -vd_scaled;
      front_nxt[0].at_y = -(34'($signed(in_volt_q)) <<< 14);
      front_nxt[0].at_z = HALF_TURN;
    end else begin
      front_nxt[0].at_x = vd_scaled;
      front_nxt[0].at_y = 34'($signed(in_volt_q)) <<< 14;
      front_nxt[0].at_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) front_r[0] <= front_nxt[0];
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_front
    localparam logic [47:0] SQ_BIT = 48'd1 << (2 * (SQRT_STEPS - 1 - k));
    localparam logic AT_ON = (k < CORDIC_STEPS);
    assign front_nxt[k+1] = front_step(front_r[k], SQ_BIT, AT_ON, ATAN_TURNS[k], k);
    always_ff @(posedge clk) begin
      if (adv) front_r[k+1] <= front_nxt[k+1];
    end
  end

  // ---------------- middle: divide and sine CORDICs ----------------
  function automatic svp_mid_t mid_step(svp_mid_t s, logic [15:0] sup, logic div_on,
                                        logic sin_on, logic [31:0] at_a, int k, int qb);
    logic [31:0] dv;
    logic signed [33:0] xs1, ys1, xs2, ys2;
    logic signed [34:0] a;
    svp_mid_t o;
    o = s;
    dv  = 32'(sup) << qb;
    a   = 35'(at_a);
    xs1 = $signed(s.s1_x) >>> k;
    ys1 = $signed(s.s1_y) >>> k;
    xs2 = $signed(s.s2_x) >>> k;
    ys2 = $signed(s.s2_y) >>> k;
    if (div_on && (s.rem >= dv)) begin
      o.rem = s.rem - dv;
      o.quo = s.quo | (16'd1 << qb);
    end
    if (sin_on) begin
      if ($signed(s.s1_z) >= 0) begin
        o.s1_x = $signed(s.s1_x) - ys1;
        o.s1_y = $signed(s.s1_y) + xs1;
        o.s1_z = $signed(s.s1_z) - a;
      end else begin
        o.s1_x = $signed(s.s1_x) + ys1;
        o.s1_y = $signed(s.s1_y) - xs1;
        o.s1_z = $signed(s.s1_z) + a;
      end
      if ($signed(s.s2_z) >= 0) begin
        o.s2_x = $signed(s.s2_x) - ys2;
        o.s2_y = $signed(s.s2_y) + xs2;
        o.s2_z = $signed(s.s2_z) - a;
      end else begin
        o.s2_x = $signed(s.s2_x) + ys2;
        o.s2_y = $signed(s.s2_y) - xs2;
        o.s2_z = $signed(s.s2_z) + a;
      end
    end
    return o;
  endfunction

  svp_mid_t mid_r   [0:MID_STEPS];
  svp_mid_t mid_nxt [0:MID_STEPS];

  svp_front_t fe;
  logic [16:0] vq_abs;
  logic [23:0] mag;
  logic [31:0] dividend;
  logic [31:0] theta32;
  logic [ANGLE_BITS-1:0] theta;
  logic [ANGLE_BITS+2:0] theta6;
  logic [2:0] sec_raw;
  logic [2:0] sec;
  logic [31:0] th_hi;

  always_comb begin
    fe       = front_r[SQRT_STEPS];
    vq_abs   = fe.vq[15] ? 17'(-$signed({fe.vq[15], fe.vq})) : {1'b0, fe.vq};
    mag      = fe.fast ? {vq_abs[15:0], 8'd0} : fe.sq_res[23:0];
    dividend = {mag, 8'd0};
    theta32  = {fe.ang, 16'd0} + (fe.fast ? QUARTER_TURN : fe.at_z);
    theta    = theta32[31 -: ANGLE_BITS];
    theta6   = (ANGLE_BITS + 3)'(theta) * (ANGLE_BITS + 3)'(6);
    sec_raw  = theta6[ANGLE_BITS+2:ANGLE_BITS];
    sec      = (sec_raw > 3'd5) ? 3'd5 : sec_raw;
    th_hi    = {theta, {(32 - ANGLE_BITS){1'b0}}};

    mid_nxt[0].neg      = fe.fast && fe.vq[15];
    mid_nxt[0].clamp    = (dividend >= lim_r) && (mag != '0);
    mid_nxt[0].mag_zero = (mag == '0);
    mid_nxt[0].sec      = sec;
    mid_nxt[0].rem      = dividend;
    mid_nxt[0].quo      = '0;
    mid_nxt[0].s1_x     = CORDIC_GAIN_Q30;
    mid_nxt[0].s1_y     = '0;
    mid_nxt[0].s1_z     = 35'({2'b0, FLOOR6[sec + 3'd1]}) - 35'({3'b0, th_hi});
    mid_nxt[0].s2_x     = CORDIC_GAIN_Q30;
    mid_nxt[0].s2_y     = '0;
    mid_nxt[0].s2_z     = 35'({3'b0, th_hi}) - 35'({2'b0, CEIL6[sec]});
  end

  always_ff @(posedge clk) begin
    if (adv) mid_r[0] <= mid_nxt[0];
  end

  for (genvar k = 0; k < MID_STEPS; k++) begin : g_mid
    localparam logic DIV_ON = (k < DIV_STEPS);
    localparam logic SIN_ON = (k < CORDIC_STEPS);
    localparam int   QB     = (k < DIV_STEPS) ? (DIV_STEPS - 1 - k) : 0;
    assign mid_nxt[k+1] = mid_step(mid_r[k], supply_r, DIV_ON, SIN_ON,
                                   ATAN_TURNS[k], k, QB);
    always_ff @(posedge clk) begin
      if (adv) mid_r[k+1] <= mid_nxt[k+1];
    end
  end

  // ---------------- tail: dwell times and duty scaling ----------------
  svp_mid_t me;
  assign me = mid_r[MID_STEPS];

  logic signed [16:0] idx_nxt, idx_r;
  logic signed [33:0] y1_r, y2_r;
  logic [2:0]         sec1_r, sec2_r, sec3_r, sec4_r, sec5_r;
  logic               clp1_r, clp2_r, clp3_r, clp4_r, clp5_r, clp6_r;
  logic [2:0]         sec6_r;

  always_comb begin
    logic [16:0] mag_idx;
    mag_idx = me.clamp ? {1'b0, IDX_LIMIT} : (me.mag_zero ? 17'd0 : {1'b0, me.quo});
    idx_nxt = me.neg ? -$signed(mag_idx) : $signed(mag_idx);
  end

  logic signed [50:0] p1, p2;
  logic signed [34:0] m1_r, m2_r;
  logic signed [52:0] q1, q2;
  logic signed [35:0] t1_r, t2_r, t1b_r, t2b_r;
  logic signed [37:0] hsum;
  logic signed [36:0] h_r;
  logic signed [37:0] ta_nxt, tb_nxt, tc_nxt, ta_r, tb_r, tc_r;
  logic signed [16:0] per_s;
  logic signed [54:0] pa, pb, pc;
  logic signed [24:0] da_r, db_r, dc_r;
  logic [15:0] duty_a_r, duty_b_r, duty_c_r;
  logic [2:0]  sector_r;
  logic        clamped_r;

  assign p1    = $signed(y1_r) * $signed(idx_r);
  assign p2    = $signed(y2_r) * $signed(idx_r);
  assign q1    = $signed(m1_r) * SQRT3_Q16;
  assign q2    = $signed(m2_r) * SQRT3_Q16;
  assign hsum  = 38'sd1073741824 - 38'(t1_r) - 38'(t2_r);
  assign per_s = $signed({1'b0, period_r});
  assign pa    = $signed(ta_r) * per_s;
  assign pb    = $signed(tb_r) * per_s;
  assign pc    = $signed(tc_r) * per_s;

  always_comb begin
    logic signed [37:0] e1, e2, eh;
    e1 = 38'(t1b_r);
    e2 = 38'(t2b_r);
    eh = 38'(h_r);
    case (sec4_r)
      3'd0: begin ta_nxt = e1 + e2 + eh; tb_nxt = e2 + eh;      tc_nxt = eh;           end
      3'd1: begin ta_nxt = e1 + eh;      tb_nxt = e1 + e2 + eh; tc_nxt = eh;           end
      3'd2: begin ta_nxt = eh;           tb_nxt = e1 + e2 + eh; tc_nxt = e2 + eh;      end
      3'd3: begin ta_nxt = eh;           tb_nxt = e1 + eh;      tc_nxt = e1 + e2 + eh; end
      3'd4: begin ta_nxt = e2 + eh;      tb_nxt = eh;           tc_nxt = e1 + e2 + eh; end
      default: begin ta_nxt = e1 + e2 + eh; tb_nxt = eh;        tc_nxt = e1 + eh;      end
    endcase
  end

  function automatic logic [15:0] sat_duty(logic signed [24:0] d, logic [15:0] per);
    if (d < 0) return 16'd0;
    if (d > $signed({9'd0, per})) return per;
    return d[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      // index and sines
      idx_r  <= idx_nxt;
      y1_r   <= me.s1_y;
      y2_r   <= me.s2_y;
      sec1_r <= me.sec;
      clp1_r <= me.clamp;
      // scale sines by the index
      m1_r   <= p1[50:16];
      m2_r   <= p2[50:16];
      sec2_r <= sec1_r;
      clp2_r <= clp1_r;
      // times sqrt(3)
      t1_r   <= q1[51:16];
      t2_r   <= q2[51:16];
      sec3_r <= sec2_r;
      clp3_r <= clp2_r;
      // half of the zero-vector time
      h_r    <= hsum[37:1];
      t1b_r  <= t1_r;
      t2b_r  <= t2_r;
      sec4_r <= sec3_r;
      clp4_r <= clp3_r;
      // phase times by sector
      ta_r   <= ta_nxt;
      tb_r   <= tb_nxt;
      tc_r   <= tc_nxt;
      sec5_r <= sec4_r;
      clp5_r <= clp4_r;
      // scale by period
      da_r   <= pa[54:30];
      db_r   <= pb[54:30];
      dc_r   <= pc[54:30];
      sec6_r <= sec5_r;
      clp6_r <= clp5_r;
      // saturate into the output word
      duty_a_r  <= sat_duty(da_r, period_r);
      duty_b_r  <= sat_duty(db_r, period_r);
      duty_c_r  <= sat_duty(dc_r, period_r);
      sector_r  <= sec6_r + 3'd1;
      clamped_r <= clp6_r;
    end
  end

  assign out_duty_a     = duty_a_r;
  assign out_duty_b     = duty_b_r;
  assign out_duty_c     = duty_c_r;
  assign out_sector_num = sector_r;
  assign out_clamped    = clamped_r;

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sector_num >= 3'd1) && (out_sector_num <= 3'd6))
    else $error("sector out of range");

  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty_a <= period_r) && (out_duty_b <= period_r)
                  && (out_duty_c <= period_r))
    else $error("duty above period");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_r) && $stable(out_duty_a))
    else $error("pipeline moved while stalled");

endmodule
